// File: rtl/pidpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared types, widths, register codes and the microcode program of the PID
// position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

   localparam int FRAC_BITS_DEFAULT = 12;

   localparam int COUNT_W = 16;
   localparam int DRIVE_W = 16;
   localparam int SETPT_W = 10;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int ERR_W   = 18;
   localparam int DERR_W  = ERR_W + 1;
   localparam int INTEG_W = 32;
   localparam int MA_W    = 20;
   localparam int MB_W    = GAIN_W + 1;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int LO_W    = 18;
   localparam int SUM_W   = PROD_W;
   localparam int ACC_W   = PROD_W + LO_W;
   localparam int ISUM_W  = PROD_W + 1;

   localparam logic signed [SETPT_W-1:0] SETPT_RST   = '0;
   localparam logic [GAIN_W-1:0]         PGAIN_RST   = 16'd2253;
   localparam logic [GAIN_W-1:0]         IGAIN_RST   = 16'd0;
   localparam logic [GAIN_W-1:0]         DGAIN_RST   = 16'd0;
   localparam logic [GAIN_W-1:0]         OGAIN_RST   = 16'd4096;
   localparam logic [LIMIT_W-1:0]        ILIMIT_RST  = 15'd140;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETPOINT     = 3'd0,
      REG_PROP_GAIN    = 3'd1,
      REG_INTEG_GAIN   = 3'd2,
      REG_DERIV_GAIN   = 3'd3,
      REG_OVERALL_GAIN = 3'd4,
      REG_INTEG_LIMIT  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [SETPT_W-1:0] setpoint;
      logic [GAIN_W-1:0]         prop_gain;
      logic [GAIN_W-1:0]         integ_gain;
      logic [GAIN_W-1:0]         deriv_gain;
      logic [GAIN_W-1:0]         overall_gain;
      logic [LIMIT_W-1:0]        integ_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'd0,
      S_MUL_KI = 4'd1,
      S_MUL_KP = 4'd2,
      S_MUL_KD = 4'd3,
      S_ADD_D  = 4'd4,
      S_MUL_HI = 4'd5,
      S_MUL_LO = 4'd6,
      S_ADD_LO = 4'd7,
      S_OUT    = 4'd8
   } step_type;

   typedef enum logic [1:0] {
      MA_ERR, MA_DERR, MA_SUM_HI, MA_SUM_LO
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_KP, MB_KI, MB_KD, MB_OG
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD_INTEG, ACC_LOAD_HI, ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS, COND_REQ, COND_OUT
   } cond_type;

   typedef struct packed {
      cond_type   cond;
      step_type   nxt;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      logic       ld_err;
      logic       integ_wr;
      logic       prev_wr;
      logic       out_wr;
   } ucode_type;

   typedef struct packed {
      logic       go;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      acc_op_type acc_op;
      logic       ld_err;
      logic       integ_wr;
      logic       prev_wr;
      logic       out_wr;
   } ctrl_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      w = '{cond: COND_ALWAYS, nxt: S_IDLE, mul_a: MA_ERR, mul_b: MB_KP,
            acc_op: ACC_HOLD, ld_err: 1'b0, integ_wr: 1'b0, prev_wr: 1'b0,
            out_wr: 1'b0};
      unique case (s)
         S_IDLE: begin
            w.cond   = COND_REQ;
            w.nxt    = S_MUL_KI;
            w.ld_err = 1'b1;
         end
         S_MUL_KI: begin
            w.nxt   = S_MUL_KP;
            w.mul_b = MB_KI;
         end
         S_MUL_KP: begin
            w.nxt      = S_MUL_KD;
            w.integ_wr = 1'b1;
         end
         S_MUL_KD: begin
            w.nxt    = S_ADD_D;
            w.mul_a  = MA_DERR;
            w.mul_b  = MB_KD;
            w.acc_op = ACC_LOAD_INTEG;
         end
         S_ADD_D: begin
            w.nxt     = S_MUL_HI;
            w.acc_op  = ACC_ADD;
            w.prev_wr = 1'b1;
         end
         S_MUL_HI: begin
            w.nxt   = S_MUL_LO;
            w.mul_a = MA_SUM_HI;
            w.mul_b = MB_OG;
         end
         S_MUL_LO: begin
            w.nxt    = S_ADD_LO;
            w.mul_a  = MA_SUM_LO;
            w.mul_b  = MB_OG;
            w.acc_op = ACC_LOAD_HI;
         end
         S_ADD_LO: begin
            w.nxt    = S_OUT;
            w.acc_op = ACC_ADD;
         end
         S_OUT: begin
            w.cond   = COND_OUT;
            w.nxt    = S_IDLE;
            w.out_wr = 1'b1;
         end
         default: begin
            w.nxt = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pidpc_csr_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_csr_regs
// Configuration register file: setpoint, gains and integral limit.
// ----------------------------------------------------------------------------
module pidpc_csr_regs (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [pidpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pidpc_pkg::CSR_DATA_W-1:0] csr_data,
   output pidpc_pkg::cfg_type                    cfg
);
   import pidpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SETPOINT:     cfg_in.setpoint     = signed'(csr_data[SETPT_W-1:0]);
            REG_PROP_GAIN:    cfg_in.prop_gain    = csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN:   cfg_in.integ_gain   = csr_data[GAIN_W-1:0];
            REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_data[GAIN_W-1:0];
            REG_OVERALL_GAIN: cfg_in.overall_gain = csr_data[GAIN_W-1:0];
            REG_INTEG_LIMIT:  cfg_in.integ_limit  = csr_data[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{setpoint: SETPT_RST, prop_gain: PGAIN_RST, integ_gain: IGAIN_RST,
                     deriv_gain: DGAIN_RST, overall_gain: OGAIN_RST,
                     integ_limit: ILIMIT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: rtl/pidpc_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_sequencer
// Step counter over the microcode program; evaluates the wait conditions
// and issues one control word per cycle.
// ----------------------------------------------------------------------------
module pidpc_sequencer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           out_free,
   output logic                busy,
   output pidpc_pkg::ctrl_type ctrl
);
   import pidpc_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type uw;
   logic      go;

   assign uw = ucode_rom(step_ff);

   always_comb begin
      unique case (uw.cond)
         COND_REQ: go = req_valid;
         COND_OUT: go = out_free;
         default:  go = 1'b1;
      endcase
   end

   always_comb begin
      step_in = go ? uw.nxt : step_ff;
   end

   always_comb begin
      ctrl.go       = go;
      ctrl.mul_a    = uw.mul_a;
      ctrl.mul_b    = uw.mul_b;
      ctrl.acc_op   = uw.acc_op;
      ctrl.ld_err   = uw.ld_err;
      ctrl.integ_wr = uw.integ_wr;
      ctrl.prev_wr  = uw.prev_wr;
      ctrl.out_wr   = uw.out_wr;
      busy          = (step_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pidpc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_datapath
// Error registers, shared multiplier, integral clamp, accumulator and the
// saturating output register.
// ----------------------------------------------------------------------------
module pidpc_datapath #(
   parameter int FRAC_BITS = pidpc_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pidpc_pkg::ctrl_type                  ctrl,
   input  wire pidpc_pkg::cfg_type                   cfg,
   input  wire logic signed [pidpc_pkg::COUNT_W-1:0] req_measured_count,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic signed [pidpc_pkg::DRIVE_W-1:0]      rsp_drive_value
);
   import pidpc_pkg::*;

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] DRV_MIN = -ACC_W'(32768);

   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DERR_W-1:0]  derr_ff, derr_in;
   logic signed [ERR_W-1:0]   prev_ff;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [ISUM_W-1:0]  isum, lim;
   logic signed [ACC_W-1:0]   shifted;

   assign err_in  = ERR_W'(cfg.setpoint) - ERR_W'(req_measured_count);
   assign derr_in = DERR_W'(err_in) - DERR_W'(prev_ff);

   always_comb begin
      case (ctrl.mul_a)
         MA_ERR:    mul_a = MA_W'(err_ff);
         MA_DERR:   mul_a = MA_W'(derr_ff);
         MA_SUM_HI: mul_a = MA_W'($signed(acc_ff[SUM_W-1:LO_W]));
         default:   mul_a = $signed({{(MA_W-LO_W){1'b0}}, acc_ff[LO_W-1:0]});
      endcase
      case (ctrl.mul_b)
         MB_KP:   mul_b = $signed({1'b0, cfg.prop_gain});
         MB_KI:   mul_b = $signed({1'b0, cfg.integ_gain});
         MB_KD:   mul_b = $signed({1'b0, cfg.deriv_gain});
         default: mul_b = $signed({1'b0, cfg.overall_gain});
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // integral update with clamp to +/- limit scaled to fraction bits
   assign isum = ISUM_W'(prod_ff) + ISUM_W'(integ_ff);
   assign lim  = $signed({{(ISUM_W-LIMIT_W){1'b0}}, cfg.integ_limit}) <<< FRAC_BITS;

   always_comb begin
      integ_in = integ_ff;
      if (ctrl.integ_wr) begin
         if (isum > lim) begin
            integ_in = INTEG_W'(lim);
         end else if (isum < -lim) begin
            integ_in = INTEG_W'(-lim);
         end else begin
            integ_in = INTEG_W'(isum);
         end
      end
   end

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD_INTEG: acc_in = ACC_W'(integ_ff) + ACC_W'(prod_ff);
         ACC_LOAD_HI:    acc_in = ACC_W'(prod_ff) <<< LO_W;
         ACC_ADD:        acc_in = acc_ff + ACC_W'(prod_ff);
         default:        acc_in = acc_ff;
      endcase
   end

   assign shifted = acc_ff >>> SHIFT;

   always_comb begin
      if (shifted > DRV_MAX) begin
         drive_in = DRIVE_W'(DRV_MAX);
      end else if (shifted < DRV_MIN) begin
         drive_in = DRIVE_W'(DRV_MIN);
      end else begin
         drive_in = DRIVE_W'(shifted);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_wr && ctrl.go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.prev_wr) begin
            prev_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.ld_err && ctrl.go) begin
         err_ff  <= err_in;
         derr_ff <= derr_in;
      end
      if (ctrl.out_wr && ctrl.go) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;

endmodule
`default_nettype wire

// File: rtl/pid_position_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_controller
// PID position controller with clamped integral and saturated drive output.
// ----------------------------------------------------------------------------
// Each measured count yields one drive value: an accept step in idle, then
// eight microcode steps that pass the integral, P, D and the two halves of
// the overall-gain product through a single shared 20x17 multiplier. A new
// count is taken once the result is loaded into the output register, so no
// count is accepted while another is in progress; the output step waits
// while a held result is stalled. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module pid_position_controller #(
   parameter int FRAC_BITS = pidpc_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [pidpc_pkg::COUNT_W-1:0] req_measured_count,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [pidpc_pkg::DRIVE_W-1:0]      rsp_drive_value,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pidpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pidpc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pidpc_pkg::*;

   cfg_type  cfg;
   ctrl_type ctrl;
   logic     busy;
   logic     out_free;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign out_free  = !rsp_valid || !rsp_stall;

   pidpc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidpc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .ctrl      (ctrl)
   );

   pidpc_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .cfg                (cfg),
      .req_measured_count (req_measured_count),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_drive_value    (rsp_drive_value)
   );

endmodule
`default_nettype wire

// File: rtl/pidpc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidpc_checker
// Port-level checks of the controller's transaction sequencing.
// ----------------------------------------------------------------------------
module pidpc_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic signed [pidpc_pkg::DRIVE_W-1:0] rsp_drive_value
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input not stalled after accepted transaction");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a transaction in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_value))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

endmodule

bind pid_position_controller pidpc_checker u_pidpc_checker (.*);
`default_nettype wire

// File: verif/pid_position_controller_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_controller_tb
// Self-checking bench for the PID position controller.
// Drives encoder counts and register writes and predicts every drive value in
// a scoreboard class that tracks error, integral and settings. It starts with
// directed extremes and then runs random phases with varied gains and random
// gaps and stalls on both transaction channels, in some phases only.
// ----------------------------------------------------------------------------
module pid_position_controller_tb;
   import pidpc_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = CSR_IDX_W'(REG_INTEG_LIMIT + 1);
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = '1;
   localparam int STYLE_TYPICAL = 0;
   localparam int STYLE_WILD    = 1;
   localparam int STYLE_EDGES   = 2;

   class drive_scoreboard;
      cfg_type                    cfg;
      logic signed [ERR_W-1:0]    last_error;
      logic signed [INTEG_W-1:0]  integral;
      logic signed [DRIVE_W-1:0]  expected_drives[$];
      int                         mismatches;
      int                         checked;

      function new();
         cfg = '{setpoint: SETPT_RST, prop_gain: PGAIN_RST, integ_gain: IGAIN_RST,
                 deriv_gain: DGAIN_RST, overall_gain: OGAIN_RST,
                 integ_limit: ILIMIT_RST};
         last_error = '0;
         integral   = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SETPOINT:     cfg.setpoint     = data[SETPT_W-1:0];
            REG_PROP_GAIN:    cfg.prop_gain    = data[GAIN_W-1:0];
            REG_INTEG_GAIN:   cfg.integ_gain   = data[GAIN_W-1:0];
            REG_DERIV_GAIN:   cfg.deriv_gain   = data[GAIN_W-1:0];
            REG_OVERALL_GAIN: cfg.overall_gain = data[GAIN_W-1:0];
            REG_INTEG_LIMIT:  cfg.integ_limit  = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_count(logic signed [COUNT_W-1:0] count);
         longint err;
         longint integ_term;
         longint lim;
         longint total;
         err = longint'($signed(cfg.setpoint)) - longint'(count);
         lim = longint'(cfg.integ_limit) <<< FRAC;
         integ_term = longint'(cfg.integ_gain) * err + longint'(integral);
         if (integ_term > lim) integ_term = lim;
         if (integ_term < -lim) integ_term = -lim;
         integral = integ_term[INTEG_W-1:0];
         total = longint'(cfg.overall_gain) *
                 (longint'(cfg.prop_gain) * err + integ_term +
                  longint'(cfg.deriv_gain) * (err - longint'(last_error)));
         total = total >>> (2 * FRAC);
         if (total > 32767) total = 32767;
         if (total < -32768) total = -32768;
         last_error = err[ERR_W-1:0];
         expected_drives.push_back(total[DRIVE_W-1:0]);
      endfunction

      function void check_drive(logic signed [DRIVE_W-1:0] actual);
         logic signed [DRIVE_W-1:0] expected;
         checked++;
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected drive transaction, expected none, actual %0d",
                     $time, actual);
            mismatches++;
         end else begin
            expected = expected_drives.pop_front();
            if (actual !== expected) begin
               $display("%0t: drive_value mismatch, expected %0d, actual %0d",
                        $time, expected, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [COUNT_W-1:0]    req_measured_count = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0]    rsp_drive_value;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;

   drive_scoreboard sb = new();
   int max_gap = 11;
   int max_stall = 11;
   int counts_sent = 0;
   int writes_done = 0;

   pid_position_controller DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_measured_count (req_measured_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_value    (rsp_drive_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_drive(rsp_drive_value);
   end

   // result side backpressure
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = $urandom_range(max_stall);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_count(input logic signed [COUNT_W-1:0] count);
      int gap;
      gap = $urandom_range(max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_measured_count <= count;
      do @(posedge clock); while (req_stall);
      sb.note_count(count);
      counts_sent++;
   endtask

   task automatic settle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      writes_done++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input int style);
      int sp;
      if (style == STYLE_TYPICAL) begin
         sp = int'($urandom_range(1000)) - 500;
         write_reg(REG_SETPOINT, {6'($urandom), 10'(sp)});
         write_reg(REG_PROP_GAIN, 16'($urandom_range(8191)));
         write_reg(REG_INTEG_GAIN, 16'($urandom_range(1023)));
         write_reg(REG_DERIV_GAIN, 16'($urandom_range(8191)));
         write_reg(REG_OVERALL_GAIN, 16'($urandom_range(8191, 2048)));
         write_reg(REG_INTEG_LIMIT, {1'($urandom), 15'($urandom_range(2000))});
      end else if (style == STYLE_WILD) begin
         write_reg(REG_SETPOINT, 16'($urandom));
         write_reg(REG_PROP_GAIN, 16'($urandom));
         write_reg(REG_INTEG_GAIN, 16'($urandom));
         write_reg(REG_DERIV_GAIN, 16'($urandom));
         write_reg(REG_OVERALL_GAIN, 16'($urandom));
         write_reg(REG_INTEG_LIMIT, 16'($urandom));
      end else begin
         write_reg(REG_SETPOINT, ($urandom_range(1) != 0) ? 16'h01FF : 16'h0200);
         write_reg(REG_PROP_GAIN, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
         write_reg(REG_INTEG_GAIN, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
         write_reg(REG_DERIV_GAIN, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
         write_reg(REG_OVERALL_GAIN, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
         write_reg(REG_INTEG_LIMIT, ($urandom_range(1) != 0) ? 16'h7FFF : 16'h0000);
      end
      if ($urandom_range(2) == 0)
         write_reg(($urandom_range(1) != 0) ? IDX_SPARE_HI : IDX_SPARE_LO, 16'($urandom));
   endtask

   function automatic logic signed [COUNT_W-1:0] pick_count(input int style);
      int roll;
      logic signed [COUNT_W-1:0] c;
      roll = $urandom_range(99);
      if (style == STYLE_WILD || roll < 10)
         c = COUNT_W'($urandom);
      else if (roll < 15)
         c = roll[0] ? 16'sh7FFF : 16'sh8000;
      else
         c = COUNT_W'(int'($signed(sb.cfg.setpoint)) + int'($urandom_range(600)) - 300);
      return c;
   endfunction

   initial begin
      int phase;
      int n;
      int style;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_count(16'sd0);
      send_count(16'sd1);
      send_count(-16'sd1);
      send_count(16'sd500);
      send_count(-16'sd500);
      send_count(16'sh7FFF);
      send_count(16'sh8000);
      settle();

      // all gains at max, setpoint beyond +/-500: saturation and wide clamp
      write_reg(REG_SETPOINT, 16'hFDFF);
      write_reg(REG_PROP_GAIN, 16'hFFFF);
      write_reg(REG_INTEG_GAIN, 16'hFFFF);
      write_reg(REG_DERIV_GAIN, 16'hFFFF);
      write_reg(REG_OVERALL_GAIN, 16'hFFFF);
      write_reg(REG_INTEG_LIMIT, 16'h7FFF);
      send_count(16'sh8000);
      send_count(16'sh8000);
      send_count(16'sh7FFF);
      send_count(16'sh7FFF);
      settle();

      // zero limit pins the integral, most negative setpoint
      write_reg(REG_SETPOINT, 16'h0200);
      write_reg(REG_INTEG_LIMIT, 16'h8000);
      write_reg(REG_OVERALL_GAIN, 16'h0001);
      write_reg(REG_DERIV_GAIN, 16'h0000);
      write_reg(REG_PROP_GAIN, 16'h1000);
      send_count(16'sd0);
      send_count(-16'sd512);
      send_count(16'sd100);
      send_count(16'sh8000);
      settle();

      // zero overall gain, then writes to unused indexes
      write_reg(REG_OVERALL_GAIN, 16'h0000);
      send_count(16'sd1234);
      send_count(-16'sd4321);
      settle();
      write_reg(IDX_SPARE_LO, 16'hFFFF);
      write_reg(IDX_SPARE_HI, 16'h1234);
      send_count(16'sd77);
      settle();

      for (phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: begin max_gap = 11; max_stall = 11; end
            1: begin max_gap = 0;  max_stall = 11; end
            2: begin max_gap = 11; max_stall = 0;  end
            default: begin max_gap = 0; max_stall = 0; end
         endcase
         style = (phase % 5 == 4) ? STYLE_EDGES :
                 (phase % 5 == 3) ? STYLE_WILD : STYLE_TYPICAL;
         load_settings(style);
         for (n = 0; n < 95; n++) send_count(pick_count(style));
         settle();
      end

      if (sb.pending() != 0) begin
         $display("%0t: %0d drive values never arrived, expected more, actual none",
                  $time, sb.pending());
         sb.mismatches += sb.pending();
      end
      $display("Run covered %0d encoder counts and %0d register writes over 10 random phases",
               counts_sent, writes_done);
      $display("Compared %0d drive values, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
